// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ----- hdl/tkf_pkg.sv -----
// ----------------------------------------------------------------------------
// Top-k frequent values package
// Shared widths, cell command structs, state codes and the rank key helper.
// ----------------------------------------------------------------------------
package tkf_pkg;

    localparam int VALUE_W  = 32;
    localparam int TOPCNT_W = 5;

    // Commands broadcast to the tally (counting) cells
    typedef struct packed {
        logic update;   // match-and-increment or allocate
        logic shift;    // move every entry one cell toward the head
    } tally_cmd_t;

    // Commands broadcast to the rank (sorting) cells
    typedef struct packed {
        logic insert;   // insert the candidate in sorted position
        logic pop;      // drop the head, move the rest up
        logic clear;    // empty the whole chain
    } rank_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    // Signed value mapped to an unsigned ordering key
    function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
        order_key = {~v[VALUE_W-1], v[VALUE_W-2:0]};
    endfunction

endpackage

// ----- hdl/tkf_tally_cell.sv -----
// ----------------------------------------------------------------------------
// Tally cell
// Holds one distinct value and its saturating count; allocates when it is
// the first free cell and shifts toward the head during the scan.
// ----------------------------------------------------------------------------
module tkf_tally_cell
    import tkf_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tally_cmd_t            cmd,
    input  logic [VALUE_W-1:0]    in_value,
    input  logic                  found,
    input  logic                  prev_valid,
    input  logic                  nxt_valid,
    input  logic [VALUE_W-1:0]    nxt_value,
    input  logic [COUNT_BITS-1:0] nxt_count,
    output logic                  valid,
    output logic [VALUE_W-1:0]    value,
    output logic [COUNT_BITS-1:0] count,
    output logic                  match
);

    logic                  valid_reg, valid_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign match = valid_reg && (value_reg == in_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        if (cmd.shift)
        begin
            valid_next = nxt_valid;
            value_next = nxt_value;
            count_next = nxt_count;
        end
        else if (cmd.update)
        begin
            if (match)
            begin
                if (count_reg != {COUNT_BITS{1'b1}})
                    count_next = count_reg + COUNT_BITS'(1);
            end
            else if (!found && !valid_reg && prev_valid)
            begin
                // first free cell takes the new value
                valid_next = 1'b1;
                value_next = in_value;
                count_next = COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign count = count_reg;

endmodule

// ----- hdl/tkf_rank_cell.sv -----
// ----------------------------------------------------------------------------
// Rank cell
// One slot of a sorted insertion chain ordered by descending (count, value).
// ----------------------------------------------------------------------------
module tkf_rank_cell
    import tkf_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rank_cmd_t             cmd,
    input  logic                  cand_valid,
    input  logic [VALUE_W-1:0]    cand_value,
    input  logic [COUNT_BITS-1:0] cand_count,
    input  logic                  prev_wins,
    input  logic                  prev_valid,
    input  logic [VALUE_W-1:0]    prev_value,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  logic                  nxt_valid,
    input  logic [VALUE_W-1:0]    nxt_value,
    input  logic [COUNT_BITS-1:0] nxt_count,
    output logic                  wins,
    output logic                  valid,
    output logic [VALUE_W-1:0]    value,
    output logic [COUNT_BITS-1:0] count
);

    logic                  valid_reg, valid_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // candidate ranks strictly above this slot (an empty slot ranks lowest)
    assign wins = cand_valid &&
                  (!valid_reg ||
                   ({cand_count, order_key(cand_value)} >
                    {count_reg, order_key(value_reg)}));

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        priority if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.pop)
        begin
            valid_next = nxt_valid;
            value_next = nxt_value;
            count_next = nxt_count;
        end
        else if (cmd.insert && wins)
        begin
            if (prev_wins)
            begin
                // push down: take the upper neighbor's entry
                valid_next = prev_valid;
                value_next = prev_value;
                count_next = prev_count;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = cand_value;
                count_next = cand_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign count = count_reg;

endmodule

// ----- hdl/top_k_frequent_values.sv -----
// ----------------------------------------------------------------------------
// Top-k frequent values
// Counts distinct values of a set in a chain of tally cells and reports the
// top_count most frequent ones through a sorted chain of rank cells.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | in_valid / in_ready       | value, last
//  result   | out_valid / out_ready     | top_value, frequency, overflowed,
//           |                           | final_res
//  config   | cfg_wr_en                 | cfg_wr_data (top_count)
//
// Each request is captured, then matched and updated in parallel across all
// tally cells. After the last request the tally chain shifts one entry per
// cycle into the rank chain, then one result per cycle is offered while
// out_ready is high; out_ready low holds the head. Reset empties both
// chains and sets top_count to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module top_k_frequent_values
    import tkf_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_TOP     = 16,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_W-1:0]    value,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_W-1:0]    top_value,
    output logic [COUNT_BITS-1:0] frequency,
    output logic                  overflowed,
    output logic                  final_res,
    input  logic                  cfg_wr_en,
    input  logic [TOPCNT_W-1:0]   cfg_wr_data
);

    localparam int KW = $clog2(MAX_TOP + 1);

    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    value_reg;
    logic                  last_reg;
    logic                  ovf_reg, ovf_next;
    logic [TOPCNT_W-1:0]   top_count_reg;
    logic [KW-1:0]         remain_reg, remain_next;
    logic [KW-1:0]         k_eff;

    tally_cmd_t            tally_cmd;
    rank_cmd_t             rank_cmd;

    // tally chain: slot 0 is a constant "occupied" head, slot D+1 is empty
    logic                  tv_chain [TABLE_DEPTH+2];
    logic [VALUE_W-1:0]    tval_chain [TABLE_DEPTH+2];
    logic [COUNT_BITS-1:0] tcnt_chain [TABLE_DEPTH+2];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic                  found;
    logic                  table_full;

    // rank chain: slot 0 and slot MAX_TOP+1 are empty padding
    logic                  rv_chain [MAX_TOP+2];
    logic [VALUE_W-1:0]    rval_chain [MAX_TOP+2];
    logic [COUNT_BITS-1:0] rcnt_chain [MAX_TOP+2];
    logic                  wins_chain [MAX_TOP+1];

    logic                  in_acc;
    logic                  out_acc;

    assign tv_chain[0]               = 1'b1;
    assign tval_chain[0]             = '0;
    assign tcnt_chain[0]             = '0;
    assign tv_chain[TABLE_DEPTH+1]   = 1'b0;
    assign tval_chain[TABLE_DEPTH+1] = '0;
    assign tcnt_chain[TABLE_DEPTH+1] = '0;

    assign rv_chain[0]           = 1'b0;
    assign rval_chain[0]         = '0;
    assign rcnt_chain[0]         = '0;
    assign rv_chain[MAX_TOP+1]   = 1'b0;
    assign rval_chain[MAX_TOP+1] = '0;
    assign rcnt_chain[MAX_TOP+1] = '0;
    assign wins_chain[0]         = 1'b0;

    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_tally
            tkf_tally_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (tally_cmd),
                .in_value   (value_reg),
                .found      (found),
                .prev_valid (tv_chain[i]),
                .nxt_valid  (tv_chain[i+2]),
                .nxt_value  (tval_chain[i+2]),
                .nxt_count  (tcnt_chain[i+2]),
                .valid      (tv_chain[i+1]),
                .value      (tval_chain[i+1]),
                .count      (tcnt_chain[i+1]),
                .match      (match_vec[i])
            );
        end

        for (genvar j = 0; j < MAX_TOP; j++)
        begin : g_rank
            tkf_rank_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (rank_cmd),
                .cand_valid (tv_chain[1]),
                .cand_value (tval_chain[1]),
                .cand_count (tcnt_chain[1]),
                .prev_wins  (wins_chain[j]),
                .prev_valid (rv_chain[j]),
                .prev_value (rval_chain[j]),
                .prev_count (rcnt_chain[j]),
                .nxt_valid  (rv_chain[j+2]),
                .nxt_value  (rval_chain[j+2]),
                .nxt_count  (rcnt_chain[j+2]),
                .wins       (wins_chain[j+1]),
                .valid      (rv_chain[j+1]),
                .value      (rval_chain[j+1]),
                .count      (rcnt_chain[j+1])
            );
        end
    endgenerate

    assign found      = |match_vec;
    assign table_full = tv_chain[TABLE_DEPTH];

    // clamp top_count to 1..MAX_TOP
    always_comb
    begin
        if (top_count_reg == '0)
            k_eff = KW'(1);
        else if (32'(top_count_reg) > 32'(MAX_TOP))
            k_eff = KW'(MAX_TOP);
        else
            k_eff = KW'(top_count_reg);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (state_reg == S_EMIT);
    assign out_acc   = out_valid && out_ready;

    assign top_value  = rval_chain[1];
    assign frequency  = rcnt_chain[1];
    assign overflowed = ovf_reg;
    assign final_res  = (remain_reg == KW'(1)) || !rv_chain[2];

    always_comb
    begin
        state_next       = state_reg;
        ovf_next         = ovf_reg;
        remain_next      = remain_reg;
        tally_cmd        = '0;
        rank_cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                tally_cmd.update = 1'b1;
                if (!found && table_full)
                    ovf_next = 1'b1;
                if (last_reg)
                begin
                    state_next  = S_SCAN;
                    remain_next = k_eff;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // drain the tally chain head into the sorter, one per cycle
                tally_cmd.shift = 1'b1;
                rank_cmd.insert = 1'b1;
                if (!tv_chain[1])
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    if (final_res)
                    begin
                        rank_cmd.clear = 1'b1;
                        ovf_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        rank_cmd.pop = 1'b1;
                        remain_next  = remain_reg - KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ovf_reg       <= 1'b0;
            remain_reg    <= '0;
            top_count_reg <= TOPCNT_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            ovf_reg    <= ovf_next;
            remain_reg <= remain_next;
            if (cfg_wr_en)
                top_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
    end

    `ASSERT_ALWAYS(a_emit_has_head, clk, rst_n, (state_reg == S_EMIT) |-> rv_chain[1])
    `ASSERT_ALWAYS(a_idle_sorter_empty, clk, rst_n, (state_reg == S_IDLE) |-> !rv_chain[1])
    `ASSERT_ALWAYS(a_final_to_idle, clk, rst_n, (out_acc && final_res) |=> (state_reg == S_IDLE))
    `ASSERT_NEVER(a_emit_table_busy, clk, rst_n, (state_reg == S_EMIT) && tv_chain[1])

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for top_k_frequent_values
// Drives data sets through the request channel, predicts the ranked report of
// each set with a behavioral tally, and checks every result field. A short
// table of directed sets comes first, then random sets with random stalls on
// both channels, a long receiver hold-off, table overflow and a full table.
// ----------------------------------------------------------------------------
module tb_top
    import tkf_pkg::*;
();

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_TOP     = 16;
    localparam int COUNT_BITS  = 16;
    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0]    rep_value;
        logic [COUNT_BITS-1:0] rep_freq;
        logic                  rep_ovf;
        logic                  rep_final;
    } report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [VALUE_W-1:0] data;
        logic               is_last;
        logic               typed;
        report_t            known;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [VALUE_W-1:0]    value;
    logic                  last;
    logic                  out_valid;
    logic                  out_ready;
    logic [VALUE_W-1:0]    top_value;
    logic [COUNT_BITS-1:0] frequency;
    logic                  overflowed;
    logic                  final_res;
    logic                  cfg_wr_en;
    logic [TOPCNT_W-1:0]   cfg_wr_data;

    // behavioral tally of the current set
    logic [VALUE_W-1:0]    tally_values [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] tally_counts [TABLE_DEPTH];
    int                    tally_used;
    logic                  tally_dropped;
    logic [TOPCNT_W-1:0]   top_count_reg;

    report_t expected_reports [$];
    report_t want;

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  sets_sent;
    int  cfg_writes;
    bit  calm;
    bit  hold_pending;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 16'd1, 1'b0, 1'b1}},
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 16'd1, 1'b0, 1'b1}},
        '{ROW_CFG,  32'd16,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd5,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd5,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd7,         1'b1, 1'b0, '0},
        '{ROW_CFG,  32'd0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd0,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd0,         1'b1, 1'b0, '0},
        '{ROW_CFG,  32'd31,        1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd0,         1'b1, 1'b1, '{32'd0, 16'd1, 1'b0, 1'b1}},
        '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 16'd1, 1'b0, 1'b1}},
        '{ROW_CFG,  32'd2,         1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_ITEM, 32'd1,         1'b1, 1'b0, '0}
    };

    top_k_frequent_values DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_value   (top_value),
        .frequency   (frequency),
        .overflowed  (overflowed),
        .final_res   (final_res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count one request into the tally; on the final one rank and queue the report.
    task automatic tally_request(input logic [VALUE_W-1:0] v, input logic fin,
                                 input logic typed, input report_t known);
        bit      found;
        bit      taken [TABLE_DEPTH];
        int      k;
        int      n;
        int      best;
        report_t rep;
        found = 1'b0;
        for (int i = 0; i < tally_used; i++)
        begin
            if (!found && tally_values[i] == v)
            begin
                if (tally_counts[i] != COUNT_MAX)
                    tally_counts[i]++;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (tally_used < TABLE_DEPTH)
            begin
                tally_values[tally_used] = v;
                tally_counts[tally_used] = COUNT_BITS'(1);
                tally_used++;
            end
            else
                tally_dropped = 1'b1;
        end
        if (!fin)
            return;
        if (typed)
            expected_reports.push_back(known);
        else
        begin
            k = (top_count_reg == 0) ? 1 : int'(top_count_reg);
            if (k > MAX_TOP)
                k = MAX_TOP;
            n = (tally_used < k) ? tally_used : k;
            foreach (taken[i])
                taken[i] = 1'b0;
            for (int r = 0; r < n; r++)
            begin
                best = -1;
                for (int i = 0; i < tally_used; i++)
                begin
                    if (taken[i])
                        continue;
                    if (best < 0 || tally_counts[i] > tally_counts[best] ||
                        (tally_counts[i] == tally_counts[best] &&
                         $signed(tally_values[i]) > $signed(tally_values[best])))
                        best = i;
                end
                taken[best] = 1'b1;
                rep.rep_value = tally_values[best];
                rep.rep_freq  = tally_counts[best];
                rep.rep_ovf   = tally_dropped;
                rep.rep_final = (r + 1 == n);
                expected_reports.push_back(rep);
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            tally_counts[i] = '0;
        tally_used    = 0;
        tally_dropped = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high afterwards so back-to-back requests need no toggle.
    task automatic offer_request(input logic [VALUE_W-1:0] v, input logic fin,
                                 input logic typed = 1'b0, input report_t known = '0);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        last     = fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tally_request(v, fin, typed, known);
        items_sent++;
        if (fin)
            sets_sent++;
        @(negedge clk);
    endtask

    task automatic drain_reports();
        in_valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_top_count(input logic [TOPCNT_W-1:0] n);
        drain_reports();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = n;
        @(negedge clk);
        cfg_wr_en     = 1'b0;
        top_count_reg = n;
        cfg_writes++;
    endtask

    function automatic logic [TOPCNT_W-1:0] pick_top_count();
        case ($urandom_range(5))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd17;
            4: return 5'd31;
            default: return 5'($urandom_range(2, 15));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_seed_value();
        case ($urandom_range(3))
            0: return VALUE_W'($urandom_range(0, 8) - 4);
            1: return $urandom;
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return VALUE_W'($urandom_range(0, 3));
        endcase
    endfunction

    // Check each report against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: value %h freq %0d ovf %b final %b",
                             top_value, frequency, overflowed, final_res);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (top_value !== want.rep_value || frequency !== want.rep_freq ||
                    overflowed !== want.rep_ovf || final_res !== want.rep_final)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.rep_value, want.rep_freq, want.rep_ovf,
                                 want.rep_final, top_value, frequency, overflowed,
                                 final_res);
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial
    begin : receiver
        int hold_left;
        bit hold_used;
        out_ready = 1'b0;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
                out_ready = calm || ($urandom_range(99) >= 21);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [VALUE_W-1:0] pool [6];
        logic [VALUE_W-1:0] base;
        int pool_n;
        int set_len;
        int set_idx;
        int rand_items;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value         = '0;
        last          = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        calm          = 1'b0;
        hold_pending  = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        sets_sent     = 0;
        cfg_writes    = 0;
        tally_used    = 0;
        tally_dropped = 1'b0;
        top_count_reg = 5'd1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tally_values[i] = '0;
            tally_counts[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_top_count(TOPCNT_W'(directed_rows[r].data));
            else
                offer_request(directed_rows[r].data, directed_rows[r].is_last,
                              directed_rows[r].typed, directed_rows[r].known);
        end

        set_idx    = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            calm = (set_idx >= 8 && set_idx < 16);
            // keep offering requests right after the hold-off starts
            if (set_idx > 0 && set_idx != 3 && $urandom_range(2) == 0)
                write_top_count(pick_top_count());
            if (set_idx == 2)
                hold_pending = 1'b1;
            if (set_idx == 4)
            begin
                // fill the table, drop new values, keep counting known ones
                base = $urandom;
                for (int i = 0; i < 70; i++)
                    offer_request(base + i, 1'b0);
                repeat (3) offer_request(base + 1, 1'b0);
                offer_request(base + 70, 1'b1);
                rand_items += 74;
            end
            else if (set_idx == 6)
            begin
                // exactly full, no drop
                base = $urandom;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    offer_request(base - i, i == TABLE_DEPTH - 1);
                rand_items += TABLE_DEPTH;
            end
            else
            begin
                pool_n = $urandom_range(1, 6);
                for (int p = 0; p < 6; p++)
                    pool[p] = pick_seed_value();
                set_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                for (int i = 0; i < set_len; i++)
                begin
                    if ($urandom_range(99) < 80)
                        offer_request(pool[$urandom_range(0, pool_n - 1)],
                                      i == set_len - 1);
                    else
                        offer_request($urandom, i == set_len - 1);
                end
                rand_items += set_len;
            end
            set_idx++;
        end
        calm = 1'b0;

        drain_reports();
        repeat (SETTLE_CYCLES) @(negedge clk);
        mismatches += expected_reports.size();
        $display("covered %0d requests in %0d sets, %0d reports checked, %0d config writes",
                 items_sent, sets_sent, results_seen, cfg_writes);
        $display("including table overflow, a full table and a long hold-off");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tkf_pkg.sv
hdl/tkf_tally_cell.sv
hdl/tkf_rank_cell.sv
hdl/top_k_frequent_values.sv
tb/tb_top.sv
